// ----- sv/mrcc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrcc_pkg
// Shared types and constants for the minimum-rank coverage curve block.
// ----------------------------------------------------------------------------
package mrcc_pkg;

  localparam int unsigned DEF_MAX_INTERVALS = 1024;
  localparam int unsigned DEF_MAX_RANKS     = 64;

  localparam logic [63:0] SIGN_BIAS = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LOW_RANK  = 2'd1,
    ST_RANK_GAP  = 2'd2,
    ST_CAPACITY  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] rank;
    logic signed [63:0] start_pos;
    logic signed [63:0] stop_pos;
    logic               final_item;
  } item_t;

  typedef struct packed {
    logic [5:0]         rank_index;
    logic [62:0]        covered;
    logic [1:0]         status;
    logic [6:0]         missing_rank;
    logic signed [31:0] seen_rank;
    logic               run_end;
  } res_t;

  // one stored interval, positions biased so unsigned compares order them
  typedef struct packed {
    logic signed [31:0] rank;
    logic [63:0]        start_b;
    logic [63:0]        stop_b;
  } rec_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_GAP_SCAN,
    S_GAP_PASS,
    S_CURVE_PASS,
    S_CURVE_STEP,
    S_EMIT
  } state_t;

endpackage

// ----- sv/mrcc_ram.sv -----
// ----------------------------------------------------------------------------
// mrcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- sv/min_rank_coverage_curve.sv -----
// ----------------------------------------------------------------------------
// min_rank_coverage_curve
// Stores intervals, then checks ranks and emits the coverage curve.
// ----------------------------------------------------------------------------
// Loading: one interval per cycle, no result for items without final_item.
// After the final beat: a check state, a rank scan over ranks 0 up to the
// highest rank or MAX_RANKS, then per rank r one sweep over the store per move
// of the sweep point (at most 2*count) plus one, and an emit state. A rank-gap
// error costs one pass over the store. Input is stalled from the final beat
// until the last result is loaded. Reset clears the state, count, flags and bounds.
module min_rank_coverage_curve #(
  parameter int unsigned MAX_INTERVALS = mrcc_pkg::DEF_MAX_INTERVALS,
  parameter int unsigned MAX_RANKS     = mrcc_pkg::DEF_MAX_RANKS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  mrcc_pkg::item_t  item,
  output logic             res_valid,
  input  logic             res_stall,
  output mrcc_pkg::res_t   res
);
  import mrcc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned GW = $clog2(MAX_RANKS + 1);

  state_t state, state_next;

  logic [CW-1:0]      count;
  logic [MAX_RANKS:0] seen;
  logic               overflow;
  logic signed [31:0] lowest, highest;

  logic [6:0]         g;
  logic signed [31:0] nxt;
  logic [5:0]         r;
  logic [63:0]        cur, total;
  logic               has_cov, has_any;
  logic [63:0]        max_stop, min_start;

  logic [CW-1:0]      pass_idx;
  logic               rd_vld, rd_en;
  rec_t               rd_rec, wr_rec;
  logic               wr_en;
  res_t               pend;

  logic               highest_ge, g_last, pass_done, out_free, seen_g;

  assign wr_rec.rank    = item.rank;
  assign wr_rec.start_b = item.start_pos ^ SIGN_BIAS;
  assign wr_rec.stop_b  = item.stop_pos ^ SIGN_BIAS;

  assign highest_ge = highest >= $signed(32'(MAX_RANKS));
  assign g_last     = highest_ge ? (32'(g) == 32'(MAX_RANKS)) : ($signed({25'd0, g}) == highest);
  assign pass_done  = (pass_idx == count) && !rd_vld;
  assign out_free   = !res_valid || !res_stall;
  assign seen_g     = seen[g[GW-1:0]];

  mrcc_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_INTERVALS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (pass_idx[AW-1:0]),
    .rd_data (rd_rec)
  );

  // control outputs
  always_comb begin
    item_stall = (state != S_LOAD);
    wr_en      = (state == S_LOAD) && item_valid && (count < CW'(MAX_INTERVALS));
    rd_en      = ((state == S_GAP_PASS) || (state == S_CURVE_PASS)) && (pass_idx != count);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:       if (item_valid && item.final_item) state_next = S_CHECK;
      S_CHECK:      state_next = (overflow || lowest != 32'sd0) ? S_EMIT : S_GAP_SCAN;
      S_GAP_SCAN: begin
        if (!seen_g)     state_next = S_GAP_PASS;
        else if (g_last) state_next = highest_ge ? S_EMIT : S_CURVE_PASS;
      end
      S_GAP_PASS:   if (pass_done) state_next = S_EMIT;
      S_CURVE_PASS: if (pass_done) state_next = S_CURVE_STEP;
      S_CURVE_STEP: state_next = (has_cov || has_any) ? S_CURVE_PASS : S_EMIT;
      S_EMIT:       if (out_free) state_next = pend.run_end ? S_LOAD : S_CURVE_PASS;
      default:      state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      seen      <= '0;
      overflow  <= 1'b0;
      lowest    <= '0;
      highest   <= '0;
      res_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (rd_en) pass_idx <= pass_idx + 1'b1;
      if (state == S_EMIT && out_free) res_valid <= 1'b1;
      else if (!res_stall)             res_valid <= 1'b0;

      unique case (state)
        S_LOAD: begin
          if (item_valid) begin
            if (count < CW'(MAX_INTERVALS)) begin
              count <= count + 1'b1;
              if (count == '0) begin
                lowest  <= item.rank;
                highest <= item.rank;
              end else begin
                if (item.rank < lowest)  lowest  <= item.rank;
                if (item.rank > highest) highest <= item.rank;
              end
              if (item.rank >= 32'sd0 && item.rank <= $signed(32'(MAX_RANKS)))
                seen[item.rank[GW-1:0]] <= 1'b1;
            end else begin
              overflow <= 1'b1;
            end
            g <= '0;
          end
        end
        S_CHECK: begin
          pend <= '{rank_index: 6'd0, covered: 63'd0,
                    status: overflow ? ST_CAPACITY
                                     : (lowest != 32'sd0 ? ST_LOW_RANK : ST_OK),
                    missing_rank: 7'd0,
                    seen_rank: overflow ? 32'sd0 : lowest,
                    run_end: 1'b1};
        end
        S_GAP_SCAN: begin
          if (!seen_g) begin
            nxt      <= highest;
            pass_idx <= '0;
          end else if (g_last) begin
            if (highest_ge) begin
              pend <= '{rank_index: 6'd0, covered: 63'd0, status: ST_CAPACITY,
                        missing_rank: 7'd0, seen_rank: 32'sd0, run_end: 1'b1};
            end else begin
              r        <= '0;
              cur      <= '0;
              total    <= '0;
              has_cov  <= 1'b0;
              has_any  <= 1'b0;
              pass_idx <= '0;
            end
          end else begin
            g <= g + 1'b1;
          end
        end
        S_GAP_PASS: begin
          if (rd_vld && rd_rec.rank > $signed({25'd0, g}) && rd_rec.rank < nxt)
            nxt <= rd_rec.rank;
          if (pass_done) begin
            pend <= '{rank_index: 6'd0, covered: 63'd0, status: ST_RANK_GAP,
                      missing_rank: g, seen_rank: nxt, run_end: 1'b1};
          end
        end
        S_CURVE_PASS: begin
          if (rd_vld && rd_rec.rank <= $signed({26'd0, r}) && rd_rec.stop_b > cur) begin
            if (rd_rec.start_b <= cur) begin
              if (!has_cov || rd_rec.stop_b > max_stop) max_stop <= rd_rec.stop_b;
              has_cov <= 1'b1;
            end else begin
              if (!has_any || rd_rec.start_b < min_start) min_start <= rd_rec.start_b;
              has_any <= 1'b1;
            end
          end
        end
        S_CURVE_STEP: begin
          has_cov  <= 1'b0;
          has_any  <= 1'b0;
          pass_idx <= '0;
          if (has_cov) begin
            // extend the covered run from cur to the furthest stop
            total <= total + (max_stop - cur);
            cur   <= max_stop;
          end else if (has_any) begin
            cur <= min_start;
          end else begin
            pend <= '{rank_index: r,
                      covered: total[63] ? {63{1'b1}} : total[62:0],
                      status: ST_OK,
                      missing_rank: 7'd0,
                      seen_rank: 32'sd0,
                      run_end: ($signed({26'd0, r}) == highest)};
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res <= pend;
            if (pend.run_end) begin
              count    <= '0;
              seen     <= '0;
              overflow <= 1'b0;
              lowest   <= '0;
              highest  <= '0;
            end else begin
              r        <= r + 1'b1;
              cur      <= '0;
              total    <= '0;
              has_cov  <= 1'b0;
              has_any  <= 1'b0;
              pass_idx <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/mrcc_checker.sv -----
// ----------------------------------------------------------------------------
// mrcc_checker
// Port-level checks for the coverage curve block, bound to the top level.
// ----------------------------------------------------------------------------
module mrcc_checker (
  input logic           clk,
  input logic           rst,
  input logic           item_stall,
  input logic           res_valid,
  input logic           res_stall,
  input mrcc_pkg::res_t res
);
  import mrcc_pkg::*;

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result valid dropped under stall");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res))
    else $error("result beat changed under stall");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.run_end && res.covered == '0)
    else $error("error beat not a lone final beat");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.run_end |-> item_stall)
    else $error("input open while curve still running");
endmodule

bind min_rank_coverage_curve mrcc_checker u_mrcc_checker (
  .clk        (clk),
  .rst        (rst),
  .item_stall (item_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res        (res)
);

// ----- tb/sv/min_rank_coverage_curve_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_rank_coverage_curve_tb
// Feeds interval data sets through the block and checks every curve point and
// error beat against a behavioural model of the minimum-rank coverage sweep.
// ----------------------------------------------------------------------------
module min_rank_coverage_curve_tb;
  import mrcc_pkg::*;

  localparam int          NUM_INTERVALS = 1024;
  localparam int          NUM_RANKS     = 64;
  localparam logic [63:0] COVER_SAT     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint      POS_MIN       = 64'sh8000_0000_0000_0000;
  localparam longint      POS_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int          CYCLE_LIMIT   = 4000000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_stall;
  item_t item = '0;
  logic  res_valid;
  logic  res_stall = 1'b0;
  res_t  res;

  min_rank_coverage_curve i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t pending_items[$];
  res_t  curve_expected[$];
  int    fail_count = 0;
  int    cycle_count = 0;
  bit    stim_done = 1'b0;

  // model state
  int          iv_rank [NUM_INTERVALS];
  logic [63:0] iv_start[NUM_INTERVALS];
  logic [63:0] iv_stop [NUM_INTERVALS];
  int          iv_count = 0;
  bit          rank_hit[NUM_RANKS+1];
  int          rank_lo = 0, rank_hi = 0;
  bit          store_full = 1'b0;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    if (a > COVER_SAT || b > COVER_SAT - a) return COVER_SAT;
    return a + b;
  endfunction

  function automatic res_t error_beat(status_t st, int miss, int seen);
    res_t r;
    r = '0;
    r.status = st;
    r.missing_rank = miss[6:0];
    r.seen_rank = seen;
    r.run_end = 1'b1;
    return r;
  endfunction

  task automatic clear_model();
    iv_count = 0;
    foreach (rank_hit[k]) rank_hit[k] = 1'b0;
    rank_lo = 0;
    rank_hi = 0;
    store_full = 1'b0;
  endtask

  task automatic emit_curve();
    logic [63:0] pts[$];
    logic [63:0] hist[NUM_RANKS];
    logic [63:0] run_total, a, b;
    int          best;
    res_t        r;
    foreach (hist[k]) hist[k] = '0;
    for (int i = 0; i < iv_count; i++) begin
      if (iv_start[i] < iv_stop[i]) begin
        pts = {pts, iv_start[i]};
        pts = {pts, iv_stop[i]};
      end
    end
    pts.sort();
    for (int k = 0; k + 1 < pts.size(); k++) begin
      a = pts[k];
      b = pts[k+1];
      if (a != b) begin
        best = -1;
        for (int i = 0; i < iv_count; i++)
          if (iv_start[i] <= a && iv_stop[i] >= b && (best < 0 || iv_rank[i] < best))
            best = iv_rank[i];
        if (best >= 0 && best < NUM_RANKS) hist[best] = sat_sum(hist[best], b - a);
      end
    end
    run_total = '0;
    for (int g = 0; g <= rank_hi; g++) begin
      run_total = sat_sum(run_total, hist[g]);
      r = '0;
      r.rank_index = g[5:0];
      r.covered = run_total[62:0];
      r.status = ST_OK;
      r.run_end = (g == rank_hi);
      curve_expected = {curve_expected, r};
    end
  endtask

  task automatic absorb_interval(item_t it);
    int probe, nxt;
    if (iv_count < NUM_INTERVALS) begin
      iv_rank[iv_count]  = it.rank;
      iv_start[iv_count] = it.start_pos ^ SIGN_BIAS;
      iv_stop[iv_count]  = it.stop_pos ^ SIGN_BIAS;
      if (iv_count == 0) begin
        rank_lo = it.rank;
        rank_hi = it.rank;
      end else begin
        if (it.rank < rank_lo) rank_lo = it.rank;
        if (it.rank > rank_hi) rank_hi = it.rank;
      end
      if (it.rank >= 0 && it.rank <= NUM_RANKS) rank_hit[it.rank] = 1'b1;
      iv_count++;
    end else begin
      store_full = 1'b1;
    end
    if (!it.final_item) return;
    if (store_full) begin
      curve_expected = {curve_expected, error_beat(ST_CAPACITY, 0, 0)};
    end else if (rank_lo != 0) begin
      curve_expected = {curve_expected, error_beat(ST_LOW_RANK, 0, rank_lo)};
    end else begin
      probe = rank_hi < NUM_RANKS ? rank_hi : NUM_RANKS;
      for (int g = 0; g <= probe; g++) begin
        if (!rank_hit[g]) begin
          nxt = rank_hi;
          for (int i = 0; i < iv_count; i++)
            if (iv_rank[i] > g && iv_rank[i] < nxt) nxt = iv_rank[i];
          curve_expected = {curve_expected, error_beat(ST_RANK_GAP, g, nxt)};
          clear_model();
          return;
        end
      end
      if (rank_hi >= NUM_RANKS)
        curve_expected = {curve_expected, error_beat(ST_CAPACITY, 0, 0)};
      else emit_curve();
    end
    clear_model();
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic queue_interval(int r, longint s, longint e, bit f);
    item_t it;
    it.rank = r;
    it.start_pos = s;
    it.stop_pos = e;
    it.final_item = f;
    pending_items = {pending_items, it};
  endtask

  function automatic longint rand64();
    return {$urandom, $urandom};
  endfunction

  // one data set: ranks 0..nranks-1 all present, then random ranks among them
  task automatic queue_set(int n, int nranks, bit wide);
    longint base, s, e;
    int     r;
    base = wide ? rand64() : longint'($urandom_range(0, 2000)) - 1000;
    for (int i = 0; i < n; i++) begin
      r = i < nranks ? i : $urandom_range(0, nranks - 1);
      if (wide) begin
        s = rand64();
        e = rand64();
      end else begin
        s = base + $urandom_range(0, 200);
        e = ($urandom_range(0, 7) == 0) ? s - $urandom_range(0, 5)
                                        : s + $urandom_range(1, 120);
      end
      queue_interval(r, s, e, i == n - 1);
    end
  endtask

  task automatic queue_noise_set();
    int n, mode;
    n = $urandom_range(1, 6);
    mode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: queue_interval($urandom, rand64(), rand64(), i == n - 1);
        1: queue_interval($urandom_range(0, 70), rand64(), rand64(), i == n - 1);
        2: queue_interval(i == 0 ? 0 : $urandom_range(0, 10),
                          $urandom_range(0, 50), $urandom_range(0, 90), i == n - 1);
        default: queue_interval(-$urandom_range(1, 3), 0, 10, i == n - 1);
      endcase
    end
  endtask

  int total_queued;

  initial begin
    // directed
    queue_interval(0, POS_MIN, POS_MAX, 1'b1);            // saturating length
    queue_interval(0, POS_MAX, POS_MIN, 1'b1);            // empty interval
    queue_interval(0, 5, 5, 1'b1);
    queue_interval(-5, 0, 10, 1'b0); queue_interval(0, 0, 10, 1'b1);       // low rank
    queue_interval(32'sh8000_0000, 0, 1, 1'b1);
    queue_interval(0, 0, 10, 1'b0); queue_interval(2, 3, 30, 1'b1);        // gap
    queue_interval(0, 0, 10, 1'b0); queue_interval(1, 5, 8, 1'b0);
    queue_interval(64, 1, 2, 1'b1);                                        // gap at rank 2, rank 64 too high
    queue_interval(0, 0, 10, 1'b0); queue_interval(1, 2, 4, 1'b0);
    queue_interval(32'sh7FFF_FFFF, 2, 4, 1'b1);                            // gap, huge rank
    queue_interval(1, -20, 40, 1'b0); queue_interval(0, 0, 10, 1'b0);
    queue_interval(2, 5, 60, 1'b0); queue_interval(0, POS_MIN, POS_MIN + 3, 1'b1);
    for (int i = 0; i < NUM_RANKS; i++)                   // every rank used
      queue_interval(i, 3 * i, 3 * i + 2 + (i % 3), i == NUM_RANKS - 1);
    queue_interval(0, 0, 7, 1'b1);                        // short clean set
    total_queued = 0;
    while (total_queued < 280) begin
      int n;
      n = $urandom_range(1, 10);
      if ($urandom_range(0, 99) < 15) begin
        queue_noise_set();
        total_queued += 3;
      end else begin
        queue_set(n, $urandom_range(1, n < 6 ? n : 6), $urandom_range(0, 9) == 0);
        total_queued += n;
      end
    end
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------- driver
  // in_taken marks a beat accepted at the last rising edge
  bit in_taken = 1'b0;
  always @(posedge clk) in_taken <= item_valid && !item_stall;

  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst && (!item_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: modes of none, light and heavy back-pressure
  int stall_mode = 0, stall_span = 0;
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(8, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      default: res_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (item_valid && !item_stall) absorb_interval(item);
      if (res_valid && !res_stall) begin
        if (curve_expected.size() == 0) begin
          $error("unexpected result beat: rank_index %0d status %0d", res.rank_index,
                 res.status);
          fail_count++;
        end else begin
          want = curve_expected.pop_front();
          if (res.rank_index !== want.rank_index) begin
            $error("rank_index: expected %0d, got %0d", want.rank_index, res.rank_index);
            fail_count++;
          end
          if (res.covered !== want.covered) begin
            $error("covered: expected %0d, got %0d", want.covered, res.covered);
            fail_count++;
          end
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            fail_count++;
          end
          if (res.missing_rank !== want.missing_rank) begin
            $error("missing_rank: expected %0d, got %0d", want.missing_rank,
                   res.missing_rank);
            fail_count++;
          end
          if (res.seen_rank !== want.seen_rank) begin
            $error("seen_rank: expected %0d, got %0d", want.seen_rank, res.seen_rank);
            fail_count++;
          end
          if (res.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, res.run_end);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait (stim_done);
    while (pending_items.size() > 0 || item_valid || curve_expected.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && curve_expected.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mrcc_pkg.sv
sv/mrcc_ram.sv
sv/min_rank_coverage_curve.sv
sv/mrcc_checker.sv
tb/sv/min_rank_coverage_curve_tb.sv
